### design/iida_pkg.sv
`timescale 1ns / 1ps
package iida_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int FILL_W = 5;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	// compare width wide enough for both the position field and the count
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_EDIT   = 3'd3,
		CMD_GET    = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_DELETE,
		OP_WRITE
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [CMP_W-1:0]       pos;
		logic [CMP_W-1:0]       cnt;
		logic [WORD_BITS-1:0]   word;
	} cell_ctl_t;

	// stored word to output word: sign-extend or truncate to the output width
	function automatic logic signed [DATA_W-1:0] read_out(input logic [WORD_BITS-1:0] w);
		logic signed [WORD_BITS-1:0] sw;
		sw = signed'(w);
		return DATA_W'(sw);
	endfunction

endpackage

### design/iida_cmd_if.sv
`timescale 1ns / 1ps
interface iida_cmd_if
	import iida_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] word_in;

	modport source (output valid, output cmd, output position, output word_in, input ready);
	modport sink   (input valid, input cmd, input position, input word_in, output ready);
endinterface

### design/iida_rsp_if.sv
`timescale 1ns / 1ps
interface iida_rsp_if
	import iida_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] word_out;
	logic [FILL_W-1:0]        fill;

	modport source (output valid, output status, output word_out, output fill, input ready);
	modport sink   (input valid, input status, input word_out, input fill, output ready);
endinterface

### design/iida_cell.sv
`timescale 1ns / 1ps
module iida_cell
	import iida_pkg::*;
(
	input  logic                 clk,
	input  logic [CMP_W-1:0]     idx,
	input  cell_ctl_t            ctl,
	input  logic [WORD_BITS-1:0] lower,
	input  logic [WORD_BITS-1:0] upper,
	output logic [WORD_BITS-1:0] word,
	output logic [WORD_BITS-1:0] rd_word
);

	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] word_d;
	logic [CMP_W-1:0]     idx_p1;

	assign idx_p1 = idx + CMP_W'(1);

	always_comb begin
		word_d = word_q;
		case (ctl.op)
			OP_INSERT: begin
				if (idx == ctl.pos)
					word_d = ctl.word;
				else if (idx > ctl.pos && idx <= ctl.cnt)
					word_d = lower;
			end
			OP_DELETE: begin
				if (idx >= ctl.pos && idx_p1 < ctl.cnt)
					word_d = upper;
			end
			OP_WRITE: begin
				if (idx == ctl.pos)
					word_d = ctl.word;
			end
			default: word_d = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word    = word_q;
	// only the addressed cell drives the shared read bus
	assign rd_word = (idx == ctl.pos) ? word_q : '0;

endmodule

### design/iida_ctrl.sv
`timescale 1ns / 1ps
module iida_ctrl
	import iida_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	iida_cmd_if.sink             request,
	iida_rsp_if.source           response,
	input  logic [WORD_BITS-1:0] rd_word,
	output cell_ctl_t            cell_ctl
);

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic                     valid_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [DATA_W-1:0] word_q;
	logic [FILL_W-1:0]        fill_q;

	logic                     take;
	logic [CMP_W-1:0]         pos;
	logic [CMP_W-1:0]         cnt;
	logic                     full;
	status_t                  status_d;
	logic signed [DATA_W-1:0] word_d;

	assign request.ready = !valid_q || response.ready;
	assign take          = request.valid && request.ready;
	assign pos           = CMP_W'(request.position);
	assign cnt           = CMP_W'(count_q);
	assign full          = (cnt == CMP_W'(DEPTH));

	always_comb begin
		cell_ctl.op   = OP_NONE;
		cell_ctl.pos  = pos;
		cell_ctl.cnt  = cnt;
		cell_ctl.word = WORD_BITS'(unsigned'(request.word_in));
		status_d      = ST_OK;
		word_d        = '0;
		count_d       = count_q;
		case (request.cmd)
			CMD_APPEND: begin
				cell_ctl.pos = cnt;
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cell_ctl.op = OP_INSERT;
					count_d     = count_q + CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				if (pos > cnt) begin
					status_d = ST_BAD_INDEX;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					cell_ctl.op = OP_INSERT;
					count_d     = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (count_q == '0) begin
					status_d = ST_UNDERFLOW;
				end else if (pos >= cnt) begin
					status_d = ST_BAD_INDEX;
				end else begin
					cell_ctl.op = OP_DELETE;
					count_d     = count_q - CNT_W'(1);
				end
			end
			CMD_EDIT: begin
				if (pos >= cnt)
					status_d = ST_BAD_INDEX;
				else
					cell_ctl.op = OP_WRITE;
			end
			CMD_GET: begin
				if (pos >= cnt)
					status_d = ST_BAD_INDEX;
				else
					word_d = read_out(rd_word);
			end
			default: status_d = ST_OK;
		endcase
		if (!take) begin
			cell_ctl.op = OP_NONE;
			count_d     = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (take)
				valid_q <= 1'b1;
			else if (response.ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_d;
			word_q   <= word_d;
			fill_q   <= FILL_W'(count_d);
		end
	end

	assign response.valid    = valid_q;
	assign response.status   = status_q;
	assign response.word_out = word_q;
	assign response.fill     = fill_q;

endmodule

### design/indexed_insert_delete_array.sv
`timescale 1ns / 1ps
// channel    dir  payload                          transaction when
// request    in   cmd[2:0] position[4:0] word_in   valid && ready
// response   out  status[1:0] word_out fill[4:0]   valid && ready
//
// Every command is carried out in the cycle it is taken: the row of cells
// shifts all entries at once; one transaction per cycle unless stalled.
// The response sits in an output register; a new request is taken while it
// is being drained, and request.ready drops only while it is stalled.
// arst_n clears the count and the response valid; cell contents stay
// undefined until written.
module indexed_insert_delete_array
	import iida_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	iida_cmd_if.sink   request,
	iida_rsp_if.source response
);

	cell_ctl_t            cell_ctl;
	logic [WORD_BITS-1:0] words   [DEPTH];
	logic [WORD_BITS-1:0] rd_bus  [DEPTH];
	logic [WORD_BITS-1:0] rd_word;

	iida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response),
		.rd_word  (rd_word),
		.cell_ctl (cell_ctl)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] lower;
		logic [WORD_BITS-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lower
			assign lower = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = words[i+1];
		end

		iida_cell u_cell (
			.clk     (clk),
			.idx     (CMP_W'(i)),
			.ctl     (cell_ctl),
			.lower   (lower),
			.upper   (upper),
			.word    (words[i]),
			.rd_word (rd_bus[i])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int k = 0; k < DEPTH; k++)
			rd_word = rd_word | rd_bus[k];
	end

endmodule
